// File: rtl/core/pap_pkg.sv
// Shared types, constants and codes for the partial amplitude profile.
`timescale 1ns / 1ps
package pap_pkg;

  localparam int unsigned PARTIAL_CAP = 128;
  localparam int unsigned NW = 33;   // rounded dividend width
  localparam int unsigned DW = 24;   // divisor width
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW = 2;

  localparam logic [16:0] ONE_Q16 = 17'd65536;
  localparam logic [16:0] HALF_Q16 = 17'd32768;

  localparam logic [2:0] MODE_TILT     = 3'd0;
  localparam logic [2:0] MODE_LOWPASS  = 3'd1;
  localparam logic [2:0] MODE_BANDPASS = 3'd2;
  localparam logic [2:0] MODE_HIGHPASS = 3'd3;
  localparam logic [2:0] MODE_NOTCH    = 3'd4;
  localparam logic [2:0] MODE_COMB     = 3'd5;
  localparam logic [2:0] MODE_VCOMB    = 3'd6;

  localparam logic [1:0] REG_MODE     = 2'd0;
  localparam logic [1:0] REG_COUNT    = 2'd1;
  localparam logic [1:0] REG_MILDNESS = 2'd2;

  typedef enum logic [2:0] {
    K_QUO,
    K_INV,
    K_TRI,
    K_ZERO,
    K_ONE
  } kind_t;

  typedef struct packed {
    logic [NW-1:0] num;
    logic [DW-1:0] den;
    kind_t         kind;
    logic [16:0]   s2;
  } pap_item_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] count;
    logic [7:0] mild;
  } pap_cfg_t;

endpackage

// File: rtl/core/pap_front.sv
// Front end: clamp, multiply and classify each beat into a division job.
`timescale 1ns / 1ps
module pap_front
  import pap_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  pap_cfg_t    cfg,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [6:0]  p_in,
  input  logic [16:0] s_in,
  output logic        job_valid,
  input  logic        job_ready,
  output pap_item_t   job
);

  logic        a_v_r;
  logic [2:0]  a_mode_r;
  logic [7:0]  a_m_r;
  logic [6:0]  a_p_r;
  logic [16:0] a_s_r;
  logic [23:0] a_c_r;
  logic [23:0] a_tp_r;
  logic [13:0] a_pp_r;
  logic        b_v_r;
  pap_item_t   b_job_r;
  logic        en;

  logic [16:0] s_cl;
  logic [7:0]  k;
  logic [24:0] c_full;
  logic [24:0] tp_full;
  logic [16:0] tfac;
  logic [7:0]  kp;

  assign en = !(b_v_r && !job_ready);
  assign in_ready = en;
  assign job_valid = b_v_r;
  assign job = b_job_r;

  always_comb begin
    s_cl = (s_in > ONE_Q16) ? ONE_Q16 : s_in;
    k = ({1'b0, p_in} + 8'd1 < cfg.count) ? (cfg.count - {1'b0, p_in} - 8'd1) : 8'd0;
    c_full = {8'd0, s_cl} * {17'd0, cfg.count};
    if (s_cl <= HALF_Q16) begin
      tfac = ONE_Q16 - {s_cl[15:0], 1'b0};
      kp = {1'b0, p_in};
    end else begin
      tfac = {s_cl[15:0], 1'b0} - ONE_Q16;
      kp = k;
    end
    tp_full = {8'd0, tfac} * {17'd0, kp};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= in_valid;
    end
    if (en) begin
      a_mode_r <= cfg.mode;
      a_m_r <= (cfg.mild == 8'd0) ? 8'd1 : cfg.mild;
      a_p_r <= p_in;
      a_s_r <= s_cl;
      a_c_r <= c_full[23:0];
      a_tp_r <= tp_full[23:0];
      a_pp_r <= 14'({7'd0, p_in} * ({7'd0, p_in} + 14'd2));
    end
  end

  logic [23:0] pq;
  logic [23:0] ad;
  logic [23:0] m16;
  logic        below;
  logic        wide;
  pap_item_t   nj;
  logic [NW-1:0] num;
  logic [DW-1:0] den;

  always_comb begin
    pq = {1'b0, a_p_r, 16'd0};
    below = pq < a_c_r;
    ad = below ? (a_c_r - pq) : (pq - a_c_r);
    m16 = {a_m_r, 16'd0};
    wide = ad >= m16;
    num = NW'(ad);
    den = DW'(a_m_r);
    nj.kind = K_ZERO;
    case (a_mode_r)
      MODE_TILT: begin
        num = NW'(64'h1_0000_0000);
        den = a_tp_r + 24'd65536;
        nj.kind = K_QUO;
      end
      MODE_LOWPASS:  nj.kind = below ? K_ONE : (wide ? K_ZERO : K_INV);
      MODE_BANDPASS: nj.kind = wide ? K_ZERO : K_INV;
      MODE_HIGHPASS: nj.kind = below ? K_ZERO : (wide ? K_ONE : K_QUO);
      MODE_NOTCH:    nj.kind = wide ? K_ONE : K_QUO;
      MODE_COMB: begin
        num = NW'(pq);
        nj.kind = K_TRI;
      end
      MODE_VCOMB: begin
        num = NW'({a_pp_r, 16'd0});
        den = DW'({a_m_r, 1'b0});
        nj.kind = K_TRI;
      end
      default: nj.kind = K_ZERO;
    endcase
    nj.num = num + NW'(den >> 1);
    nj.den = den;
    nj.s2 = {a_s_r[15:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (en) begin
      b_v_r <= a_v_r;
    end
    if (en) begin
      b_job_r <= nj;
    end
  end

endmodule

// File: rtl/core/pap_queue.sv
// Short job queue between the front end and the divider.
`timescale 1ns / 1ps
module pap_queue
  import pap_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  pap_item_t push_item,
  output logic      full,
  input  logic      pop,
  output logic      not_empty,
  output pap_item_t head
);

  pap_item_t       mem_r [QDEPTH];
  logic [QAW-1:0]  wp_r;
  logic [QAW-1:0]  rp_r;
  logic [QAW:0]    cnt_r;

  assign full = cnt_r == (QAW+1)'(QDEPTH);
  assign not_empty = cnt_r != '0;
  assign head = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      case ({push, pop})
        2'b10: cnt_r <= cnt_r + 1'b1;
        2'b01: cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
    if (push) mem_r[wp_r] <= push_item;
  end

endmodule

// File: rtl/core/pap_back.sv
// Back end: pipelined rounding divider, one quotient bit per stage, and weight shaping.
`timescale 1ns / 1ps
module pap_back
  import pap_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        job_valid,
  output logic        job_pop,
  input  pap_item_t   job,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [16:0] weight
);

  logic            v_r   [NW];
  logic [DW-1:0]   rem_r [NW];
  logic [NW-1:0]   n_r   [NW];
  logic [NW-1:0]   q_r   [NW];
  logic [DW-1:0]   d_r   [NW];
  kind_t           k_r   [NW];
  logic [16:0]     s2_r  [NW];

  logic            st_v   [NW];
  logic [DW-1:0]   st_rem [NW];
  logic [NW-1:0]   st_n   [NW];
  logic [NW-1:0]   st_q   [NW];
  logic [DW-1:0]   st_d   [NW];
  kind_t           st_k   [NW];
  logic [16:0]     st_s2  [NW];

  logic        out_v_r;
  logic [16:0] w_r;
  logic        en;

  assign en = !out_v_r || out_ready;
  assign job_pop = en && job_valid;
  assign out_valid = out_v_r;
  assign weight = w_r;

  assign st_v[0] = job_valid;
  assign st_rem[0] = '0;
  assign st_n[0] = job.num;
  assign st_q[0] = '0;
  assign st_d[0] = job.den;
  assign st_k[0] = job.kind;
  assign st_s2[0] = job.s2;

  for (genvar i = 0; i < NW; i++) begin : g_stage
    logic [DW:0] sh;
    logic        ge;

    if (i > 0) begin : g_link
      assign st_v[i] = v_r[i-1];
      assign st_rem[i] = rem_r[i-1];
      assign st_n[i] = n_r[i-1];
      assign st_q[i] = q_r[i-1];
      assign st_d[i] = d_r[i-1];
      assign st_k[i] = k_r[i-1];
      assign st_s2[i] = s2_r[i-1];
    end

    assign sh = {st_rem[i], st_n[i][NW-1]};
    assign ge = sh >= {1'b0, st_d[i]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= st_v[i];
      end
      if (en) begin
        rem_r[i] <= ge ? DW'(sh - {1'b0, st_d[i]}) : DW'(sh);
        n_r[i] <= {st_n[i][NW-2:0], 1'b0};
        q_r[i] <= {st_q[i][NW-2:0], ge};
        d_r[i] <= st_d[i];
        k_r[i] <= st_k[i];
        s2_r[i] <= st_s2[i];
      end
    end
  end

  logic [NW-1:0] q;
  logic [16:0]   r;
  logic [16:0]   w_nxt;

  always_comb begin
    q = q_r[NW-1];
    r = q[16:0] + s2_r[NW-1];
    case (k_r[NW-1])
      K_QUO:  w_nxt = (q > NW'(ONE_Q16)) ? ONE_Q16 : q[16:0];
      K_INV:  w_nxt = ONE_Q16 - q[16:0];
      K_TRI:  w_nxt = (r >= ONE_Q16) ? (r - ONE_Q16) : (ONE_Q16 - r);
      K_ONE:  w_nxt = ONE_Q16;
      default: w_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= v_r[NW-1];
    end
    if (en) begin
      w_r <= w_nxt;
    end
  end

endmodule

// File: rtl/core/partial_amplitude_profile.sv
// Top level of the partial amplitude profile.
`timescale 1ns / 1ps
// Returns the Q1.16 gain of one partial for the selected spectral profile.
// One beat in, one beat out, in order; a new beat is taken every cycle unless the job queue is full.
// Between the accepting edge and out_tvalid lie the second
// front stage, the queue write, one stage per quotient bit of the 33-bit
// rounding divider, then the output register. A four-entry
// queue lets the front keep taking beats while the result side stalls.
// Write registers only while idle; mode 7 yields zero.
module partial_amplitude_profile
  import pap_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [6:0] partial_index, [23:7] shape_position
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [16:0] weight, [23:17] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  pap_cfg_t    cfg_r;
  logic        job_valid;
  logic        q_full;
  logic        q_ne;
  logic        q_pop;
  pap_item_t   job;
  pap_item_t   head;
  logic [16:0] weight;
  logic        push;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode <= MODE_COMB;
      cfg_r.count <= 8'd30;
      cfg_r.mild <= 8'd7;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MODE:     cfg_r.mode <= cfg_data[2:0];
        REG_COUNT:    cfg_r.count <= (cfg_data > 8'(PARTIAL_CAP)) ? 8'(PARTIAL_CAP)
                                                                    : cfg_data;
        REG_MILDNESS: cfg_r.mild <= cfg_data;
        default:      cfg_r <= cfg_r;
      endcase
    end
  end

  pap_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .p_in      (in_tdata[6:0]),
    .s_in      (in_tdata[23:7]),
    .job_valid (job_valid),
    .job_ready (!q_full),
    .job       (job)
  );

  assign push = job_valid && !q_full;

  pap_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (job),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_ne),
    .head      (head)
  );

  pap_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (q_ne),
    .job_pop   (q_pop),
    .job       (head),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .weight    (weight)
  );

  assign out_tdata = {7'd0, weight};

`ifndef SYNTHESIS
  a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[16:0] <= ONE_Q16)
    else $error("weight above unity");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !push)
    else $error("push into full queue");
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_ne)
    else $error("pop from empty queue");
`endif

endmodule

// File: tb/sv/partial_amplitude_profile_checker.sv
// Checker for the partial amplitude profile: predicts each weight and compares result beats.
`timescale 1ns / 1ps
module partial_amplitude_profile_checker
  import pap_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output int          fail_count,
  output int          pending
);

  logic [2:0]  mode_q;
  logic [7:0]  count_q;
  logic [7:0]  mild_q;
  logic [16:0] weight_q[$];

  assign pending = weight_q.size();

  function automatic logic [63:0] rdiv(input logic [63:0] num, input logic [63:0] den);
    return (num + den / 2) / den;
  endfunction

  function automatic logic [16:0] tri_wave(input logic [63:0] x);
    logic [63:0] r;
    r = x & 64'h1FFFF;
    return (r >= 65536) ? 17'(r - 65536) : 17'(65536 - r);
  endfunction

  function automatic logic [16:0] profile_weight(input logic [6:0] pidx,
                                                 input logic [16:0] pos);
    logic [63:0] p, s, m, pq, c, m16, ad, w, k;
    logic below;
    p = pidx;
    s = (pos > ONE_Q16) ? 64'd65536 : 64'(pos);
    m = (mild_q == 0) ? 64'd1 : 64'(mild_q);
    pq = p << 16;
    c = s * count_q;
    m16 = m << 16;
    below = pq < c;
    ad = below ? c - pq : pq - c;
    w = 0;
    case (mode_q)
      MODE_TILT: begin
        if (s <= 32768) w = rdiv(64'd1 << 32, p * (65536 - 2 * s) + 65536);
        else begin
          k = (p + 1 < count_q) ? count_q - p - 1 : 0;
          w = rdiv(64'd1 << 32, k * (2 * s - 65536) + 65536);
        end
      end
      MODE_LOWPASS:  w = below ? 65536 : (ad >= m16) ? 0 : 65536 - rdiv(ad, m);
      MODE_BANDPASS: w = (ad >= m16) ? 0 : 65536 - rdiv(ad, m);
      MODE_HIGHPASS: w = below ? 0 : (ad >= m16) ? 65536 : rdiv(ad, m);
      MODE_NOTCH:    w = (ad >= m16) ? 65536 : rdiv(ad, m);
      MODE_COMB:     w = tri_wave(rdiv(pq, m) + 2 * s);
      MODE_VCOMB:    w = tri_wave(rdiv((p * (p + 2)) << 16, 2 * m) + 2 * s);
      default:       w = 0;
    endcase
    if (w > 65536) w = 65536;
    return w[16:0];
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      mode_q <= MODE_COMB;
      count_q <= 8'd30;
      mild_q <= 8'd7;
      fail_count <= 0;
      weight_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MODE:     mode_q <= cfg_data[2:0];
          REG_COUNT:    count_q <= (cfg_data > PARTIAL_CAP) ? 8'(PARTIAL_CAP) : cfg_data;
          REG_MILDNESS: mild_q <= cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        weight_q.push_back(profile_weight(in_tdata[6:0], in_tdata[23:7]));
      if (out_tvalid && out_tready) begin
        if (weight_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result beat %h", out_tdata);
          fail_count <= fail_count + 1;
        end else begin
          if (out_tdata !== {7'd0, weight_q[0]}) begin
            if (fail_count < 10)
              $display("weight mismatch: expected %0d actual %0d (tdata %h)",
                       weight_q[0], out_tdata[16:0], out_tdata);
            fail_count <= fail_count + 1;
          end
          void'(weight_q.pop_front());
        end
      end
    end
  end

endmodule

// File: tb/sv/partial_amplitude_profile_tb.sv
// Top of the partial amplitude profile testbench: stimulus, watchdog and verdict.
`timescale 1ns / 1ps
module partial_amplitude_profile_tb;
  import pap_pkg::*;

  localparam int LATENCY = 36;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // [6:0] partial_index, [23:7] shape_position
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // [16:0] weight, [23:17] zero
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_data;
  int          fail_count;
  int          pending;
  int          idle_cycles;
  bit          calm;

  partial_amplitude_profile uut (.*);

  partial_amplitude_profile_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)
        || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // stall the result side in bursts
  initial begin
    int n;
    out_tready = 0;
    @(posedge clk iff rst_n);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 11);
        out_tready <= 0;
        repeat (n) @(posedge clk);
      end else begin
        out_tready <= 1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic send_item(input logic [6:0] pidx, input logic [16:0] pos);
    if (!calm && $urandom_range(0, 9) == 0) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {pos, pidx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic end_burst();
    in_tvalid <= 0;
  endtask

  function automatic logic [16:0] random_position();
    case ($urandom_range(0, 5))
      0: return 17'd0;
      1: return 17'd65536;
      2: return 17'($urandom_range(65537, 131071));
      3: return 17'd32768 + 17'($urandom_range(0, 2)) - 17'd1;
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  initial begin
    logic [7:0] cnt, mil;
    calm = 0;
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    cfg_valid = 0;
    cfg_index = REG_MODE;
    cfg_data = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // reset settings, extremes of the fields
    send_item(7'd0, 17'd0);
    send_item(7'd127, 17'd65536);
    send_item(7'd127, 17'h1FFFF);
    send_item(7'd30, 17'd32768);
    end_burst();
    drain();

    // every mode, centre and edges, with extreme registers
    for (int md = 0; md < 8; md++) begin
      write_reg(REG_MODE, 8'(md));
      write_reg(REG_COUNT, (md % 2) ? 8'd255 : 8'd1);
      write_reg(REG_MILDNESS, (md == 3) ? 8'd0 : (md % 2) ? 8'd128 : 8'd1);
      send_item(7'd0, 17'd0);
      send_item(7'd64, 17'd32768);
      send_item(7'd127, 17'd65536);
      end_burst();
      drain();
    end
    // bandpass and notch exactly at the centre and at band edges
    write_reg(REG_COUNT, 8'd64);
    write_reg(REG_MILDNESS, 8'd4);
    for (int md = MODE_BANDPASS; md <= MODE_NOTCH; md += 2) begin
      write_reg(REG_MODE, 8'(md));
      send_item(7'd32, 17'd32768);
      send_item(7'd36, 17'd32768);
      send_item(7'd28, 17'd32768);
      end_burst();
      drain();
    end

    // random phases of about 100 items each
    for (int ph = 0; ph < 15; ph++) begin
      if (ph == 12) calm = 1;
      write_reg(REG_MODE, 8'($urandom_range(0, 7)));
      case ($urandom_range(0, 3))
        0: cnt = 8'd1;
        1: cnt = 8'd128;
        2: cnt = 8'($urandom_range(129, 255));
        default: cnt = 8'($urandom_range(1, 127));
      endcase
      case ($urandom_range(0, 3))
        0: mil = 8'($urandom_range(0, 1));
        1: mil = 8'($urandom_range(128, 255));
        default: mil = 8'($urandom_range(2, 20));
      endcase
      write_reg(REG_COUNT, cnt);
      write_reg(REG_MILDNESS, mil);
      write_reg(REG_UNUSED, 8'($urandom));
      repeat (100) send_item(7'($urandom_range(0, 127)), random_position());
      end_burst();
      drain();
    end

    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

// File: sim.f
rtl/core/pap_pkg.sv
rtl/core/pap_front.sv
rtl/core/pap_queue.sv
rtl/core/pap_back.sv
rtl/core/partial_amplitude_profile.sv
tb/sv/partial_amplitude_profile_checker.sv
tb/sv/partial_amplitude_profile_tb.sv
